>>> design/carp_pkg.sv
// Package: types, register map, micro-operation codes and the control program of the controller.
package carp_pkg;

	localparam int GAIN_W = 24;
	localparam int ILIM_W = 16;
	localparam int OLIM_W = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int STEP_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_KP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_KD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd6;

	localparam logic [GAIN_W-1:0] RST_OUTER_KP = 24'd245760;
	localparam logic [GAIN_W-1:0] RST_OUTER_KI = 24'd205;
	localparam logic [GAIN_W-1:0] RST_OUTER_KD = 24'd163840;
	localparam logic [GAIN_W-1:0] RST_INNER_KP = 24'd12288;
	localparam logic [GAIN_W-1:0] RST_INNER_KD = 24'd53248;
	localparam logic [ILIM_W-1:0] RST_INT_LIMIT = 16'd1000;
	localparam logic [OLIM_W-1:0] RST_OUT_LIMIT = 15'd4800;

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_PREP = 4'd1;
	localparam logic [3:0] OP_INTEG = 4'd2;
	localparam logic [3:0] OP_ACC_LOAD = 4'd3;
	localparam logic [3:0] OP_ACC_ADD = 4'd4;
	localparam logic [3:0] OP_FORM_S = 4'd5;
	localparam logic [3:0] OP_MAG_B = 4'd6;
	localparam logic [3:0] OP_HI_CHK = 4'd7;
	localparam logic [3:0] OP_LO_ADD = 4'd8;
	localparam logic [3:0] OP_APPLY = 4'd9;
	localparam logic [3:0] OP_DIV = 4'd10;
	localparam logic [3:0] OP_CLAMP = 4'd11;
	localparam logic [3:0] OP_SAT = 4'd12;
	localparam logic [3:0] OP_EMIT = 4'd13;

	localparam logic [2:0] A_KP_O = 3'd0;
	localparam logic [2:0] A_KI_O = 3'd1;
	localparam logic [2:0] A_KD_O = 3'd2;
	localparam logic [2:0] A_KP_I = 3'd3;
	localparam logic [2:0] A_KD_I = 3'd4;

	localparam logic [2:0] B_ERR = 3'd0;
	localparam logic [2:0] B_INTEG = 3'd1;
	localparam logic [2:0] B_DELTA = 3'd2;
	localparam logic [2:0] B_DG = 3'd3;
	localparam logic [2:0] B_HI = 3'd4;
	localparam logic [2:0] B_LO = 3'd5;

	localparam logic [1:0] J_NONE = 2'd0;
	localparam logic [1:0] J_SAT = 2'd1;
	localparam logic [1:0] J_ALWAYS = 2'd2;

	localparam logic [STEP_W-1:0] STEP_SAT = 4'd13;
	localparam logic [STEP_W-1:0] STEP_EMIT = 4'd14;

	typedef struct packed {
		logic [3:0]        op;
		logic [2:0]        asel;
		logic [2:0]        bsel;
		logic [1:0]        jcond;
		logic [STEP_W-1:0] jtarget;
	} carp_ctrl_t;

	localparam carp_ctrl_t CTRL_IDLE = '{OP_NOP, A_KP_O, B_ERR, J_NONE, 4'd0};

	function automatic carp_ctrl_t ucode(input logic [STEP_W-1:0] step);
		carp_ctrl_t w;
		case (step)
			4'd0: w = '{OP_PREP, A_KP_O, B_ERR, J_NONE, 4'd0};
			4'd1: w = '{OP_INTEG, A_KP_O, B_ERR, J_NONE, 4'd0};
			4'd2: w = '{OP_ACC_LOAD, A_KI_O, B_INTEG, J_NONE, 4'd0};
			4'd3: w = '{OP_ACC_ADD, A_KD_O, B_DELTA, J_NONE, 4'd0};
			4'd4: w = '{OP_ACC_ADD, A_KP_O, B_ERR, J_NONE, 4'd0};
			4'd5: w = '{OP_FORM_S, A_KD_I, B_DG, J_NONE, 4'd0};
			4'd6: w = '{OP_MAG_B, A_KP_I, B_HI, J_NONE, 4'd0};
			4'd7: w = '{OP_NOP, A_KP_I, B_HI, J_NONE, 4'd0};
			4'd8: w = '{OP_HI_CHK, A_KP_I, B_LO, J_NONE, 4'd0};
			4'd9: w = '{OP_LO_ADD, A_KP_I, B_LO, J_SAT, STEP_SAT};
			4'd10: w = '{OP_APPLY, A_KP_O, B_ERR, J_NONE, 4'd0};
			4'd11: w = '{OP_DIV, A_KP_O, B_ERR, J_NONE, 4'd0};
			4'd12: w = '{OP_CLAMP, A_KP_O, B_ERR, J_ALWAYS, STEP_EMIT};
			4'd13: w = '{OP_SAT, A_KP_O, B_ERR, J_NONE, 4'd0};
			4'd14: w = '{OP_EMIT, A_KP_O, B_ERR, J_NONE, 4'd0};
			default: w = '{OP_NOP, A_KP_O, B_ERR, J_ALWAYS, STEP_EMIT};
		endcase
		return w;
	endfunction

endpackage

>>> design/carp_seq.sv
// Step counter and microcode lookup that drive the controller datapath.
module carp_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                sat,
	input  logic                emit_ok,
	output logic                busy,
	output carp_pkg::carp_ctrl_t ctrl
);

	logic                         busy_q;
	logic [carp_pkg::STEP_W-1:0]  pc_q;
	carp_pkg::carp_ctrl_t         word;
	logic                         taken;

	assign word = carp_pkg::ucode(pc_q);
	assign ctrl = busy_q ? word : carp_pkg::CTRL_IDLE;
	assign busy = busy_q;
	assign taken = (word.jcond == carp_pkg::J_ALWAYS) ||
		((word.jcond == carp_pkg::J_SAT) && sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q <= '0;
			end
		end else if (word.op == carp_pkg::OP_EMIT) begin
			if (emit_ok) begin
				busy_q <= 1'b0;
			end
		end else if (taken) begin
			pc_q <= word.jtarget;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

endmodule

>>> design/cascaded_angle_rate_pid.sv
// Top level: cascaded angle and rate controller with a microcoded shared-multiplier datapath.
// Usage: each transaction on the slave stream is one control tick carrying the target angle,
// the gyro rate and the measured angle. The block answers each tick with exactly one
// transaction on the master stream holding the saturated drive value.
// Gains and limits are written through the plain write port (cfg_we, cfg_index, cfg_data);
// the user must write them only while no tick is in progress, as the block does not enforce
// this. Indexes beyond the register list are ignored. A tick is worked through by a microcode
// program of fifteen steps on one 25 x 25 bit multiplier with a registered product; when the
// inner product is large enough to force saturation, the program jumps to its saturation step.
// A new tick is taken only after the program for the previous one has ended: s_tready is
// low while a tick is being worked through. The result waits in an output register; the
// next tick is taken while it waits. If the receiver is still stalling when the next result
// is ready, the program holds at its final step until the register is free.
// Reset clears the integral and the stored angle and rate, restores the default gains and
// limits, and leaves both streams empty.
module cascaded_angle_rate_pid #(
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // target_angle[15:0], gyro_rate[31:16], measured_angle[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // drive_value[15:0]
	input  logic        cfg_we,
	input  logic [carp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [carp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DIV_SHIFT = 2 * GAIN_FRAC_BITS + 1;
	localparam logic signed [63:0] RND_MASK = (64'sd1 <<< DIV_SHIFT) - 64'sd1;

	logic [carp_pkg::GAIN_W-1:0] outer_kp_q, outer_ki_q, outer_kd_q, inner_kp_q, inner_kd_q;
	logic [carp_pkg::ILIM_W-1:0] int_limit_q;
	logic [carp_pkg::OLIM_W-1:0] out_limit_q;

	logic signed [15:0] target_q, gyro_q, meas_q;
	logic signed [15:0] prev_angle_q, prev_rate_q;
	logic signed [17:0] integral_q;
	logic signed [16:0] err_q, delta_q, dg_q;
	logic signed [18:0] g7_q;
	logic signed [49:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [47:0] s_q;
	logic [46:0]        mag_q;
	logic               neg_q, sat_q;
	logic [63:0]        a_q;
	logic [15:0]        drive_q;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	carp_pkg::carp_ctrl_t ctrl;
	logic                 busy, accept, emit_ok;
	logic signed [24:0]   mul_a, mul_b;
	logic signed [18:0]   int_sum, int_lim;
	logic signed [63:0]   olim64, rounded;
	logic signed [15:0]   olim16;

	assign accept = s_tvalid && s_tready;
	assign s_tready = !busy;
	assign emit_ok = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	carp_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.sat     (sat_q),
		.emit_ok (emit_ok),
		.busy    (busy),
		.ctrl    (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_kp_q <= carp_pkg::RST_OUTER_KP;
			outer_ki_q <= carp_pkg::RST_OUTER_KI;
			outer_kd_q <= carp_pkg::RST_OUTER_KD;
			inner_kp_q <= carp_pkg::RST_INNER_KP;
			inner_kd_q <= carp_pkg::RST_INNER_KD;
			int_limit_q <= carp_pkg::RST_INT_LIMIT;
			out_limit_q <= carp_pkg::RST_OUT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				carp_pkg::REG_OUTER_KP: outer_kp_q <= cfg_data;
				carp_pkg::REG_OUTER_KI: outer_ki_q <= cfg_data;
				carp_pkg::REG_OUTER_KD: outer_kd_q <= cfg_data;
				carp_pkg::REG_INNER_KP: inner_kp_q <= cfg_data;
				carp_pkg::REG_INNER_KD: inner_kd_q <= cfg_data;
				carp_pkg::REG_INT_LIMIT: int_limit_q <= cfg_data[carp_pkg::ILIM_W-1:0];
				carp_pkg::REG_OUT_LIMIT: out_limit_q <= cfg_data[carp_pkg::OLIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ctrl.asel)
			carp_pkg::A_KP_O: mul_a = $signed({1'b0, outer_kp_q});
			carp_pkg::A_KI_O: mul_a = $signed({1'b0, outer_ki_q});
			carp_pkg::A_KD_O: mul_a = $signed({1'b0, outer_kd_q});
			carp_pkg::A_KP_I: mul_a = $signed({1'b0, inner_kp_q});
			carp_pkg::A_KD_I: mul_a = $signed({1'b0, inner_kd_q});
			default: mul_a = '0;
		endcase
		case (ctrl.bsel)
			carp_pkg::B_ERR: mul_b = 25'(err_q);
			carp_pkg::B_INTEG: mul_b = 25'(integral_q);
			carp_pkg::B_DELTA: mul_b = 25'(delta_q);
			carp_pkg::B_DG: mul_b = 25'(dg_q);
			carp_pkg::B_HI: mul_b = $signed({2'b00, mag_q[46:24]});
			carp_pkg::B_LO: mul_b = $signed({1'b0, mag_q[23:0]});
			default: mul_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign int_sum = 19'(integral_q) + 19'(err_q);
	assign int_lim = $signed({3'b000, int_limit_q});
	assign olim64 = $signed({49'd0, out_limit_q});
	assign olim16 = $signed({1'b0, out_limit_q});
	assign rounded = acc_q + (acc_q[63] ? RND_MASK : 64'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_angle_q <= '0;
			prev_rate_q <= '0;
		end else if (ctrl.op == carp_pkg::OP_PREP) begin
			prev_angle_q <= meas_q;
			prev_rate_q <= gyro_q;
		end else if (ctrl.op == carp_pkg::OP_INTEG) begin
			if (int_sum > int_lim) begin
				integral_q <= 18'(int_lim);
			end else if (int_sum < -int_lim) begin
				integral_q <= 18'(-int_lim);
			end else begin
				integral_q <= 18'(int_sum);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= s_tdata[15:0];
			gyro_q <= s_tdata[31:16];
			meas_q <= s_tdata[47:32];
		end
		case (ctrl.op)
			carp_pkg::OP_PREP: begin
				err_q <= 17'(meas_q) - 17'(target_q);
				delta_q <= 17'(meas_q) - 17'(prev_angle_q);
				dg_q <= 17'(gyro_q) - 17'(prev_rate_q);
				g7_q <= (19'(gyro_q) <<< 3) - 19'(gyro_q);
			end
			carp_pkg::OP_ACC_LOAD: acc_q <= 64'(prod_q);
			carp_pkg::OP_ACC_ADD: acc_q <= acc_q + 64'(prod_q);
			carp_pkg::OP_FORM_S: begin
				s_q <= $signed(acc_q[47:0] <<< 1) + (48'(g7_q) <<< GAIN_FRAC_BITS);
			end
			carp_pkg::OP_MAG_B: begin
				neg_q <= s_q[47];
				mag_q <= s_q[47] ? 47'(-s_q) : 47'(s_q);
				acc_q <= 64'(prod_q) <<< (GAIN_FRAC_BITS + 1);
			end
			carp_pkg::OP_HI_CHK: begin
				sat_q <= |prod_q[49:38];
				a_q <= {2'b00, prod_q[37:0], 24'd0};
			end
			carp_pkg::OP_LO_ADD: a_q <= a_q + {16'd0, prod_q[47:0]};
			carp_pkg::OP_APPLY: begin
				acc_q <= neg_q ? acc_q - $signed(a_q) : acc_q + $signed(a_q);
			end
			carp_pkg::OP_DIV: acc_q <= rounded >>> DIV_SHIFT;
			carp_pkg::OP_CLAMP: begin
				if (acc_q > olim64) begin
					drive_q <= olim16;
				end else if (acc_q < -olim64) begin
					drive_q <= -olim16;
				end else begin
					drive_q <= acc_q[15:0];
				end
			end
			carp_pkg::OP_SAT: drive_q <= neg_q ? -olim16 : olim16;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((ctrl.op == carp_pkg::OP_EMIT) && emit_ok) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == carp_pkg::OP_EMIT) && emit_ok) begin
			m_tdata_q <= drive_q;
		end
	end

	a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("a second tick was taken while the program was running");

	a_output_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= olim16) && ($signed(m_tdata) >= -olim16))
		else $error("drive value outside the output limit");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctrl.op == carp_pkg::OP_EMIT))
		else $error("result presented without the final program step");

	a_ready_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == carp_pkg::OP_EMIT) && emit_ok |=> s_tready && m_tvalid)
		else $error("block did not return to ready with a result after the final step");

endmodule

>>> verif/cascaded_angle_rate_pid_checker.sv
// Checker for the cascaded angle and rate controller: predicts each drive value and compares it.
module cascaded_angle_rate_pid_checker
	import carp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [47:0]           s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [15:0]           m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    ticks_seen,
	output int                    results_checked
);

	localparam int FRAC = 12;

	logic [GAIN_W-1:0] outer_p, outer_i, outer_d, rate_p, rate_d;
	logic [ILIM_W-1:0] integ_clamp;
	logic [OLIM_W-1:0] drive_clamp;
	longint angle_err_sum;
	longint last_angle;
	longint last_rate;
	logic signed [15:0] drive_q[$];

	function automatic logic signed [15:0] predict_drive(input logic signed [15:0] tgt,
			input logic signed [15:0] gyr, input logic signed [15:0] mea);
		longint e, d, outer, s, dg, b, a, res, lim, olim, unit, denom;
		longint unsigned mag, hi, lo, kp;
		lim = longint'(integ_clamp);
		olim = longint'(drive_clamp);
		unit = longint'(1) << FRAC;
		denom = longint'(1) << (2 * FRAC + 1);
		e = longint'(mea) - longint'(tgt);
		angle_err_sum = angle_err_sum + e;
		if (angle_err_sum > lim)
			angle_err_sum = lim;
		else if (angle_err_sum < -lim)
			angle_err_sum = -lim;
		d = longint'(mea) - last_angle;
		last_angle = longint'(mea);
		outer = longint'(outer_p) * e + longint'(outer_i) * angle_err_sum
			+ longint'(outer_d) * d;
		s = 2 * outer + 7 * longint'(gyr) * unit;
		dg = longint'(gyr) - last_rate;
		last_rate = longint'(gyr);
		b = longint'(rate_d) * dg * 2 * unit;
		mag = (s < 0) ? longint'(0) - s : s;
		hi = mag >> 24;
		lo = mag & 64'hFF_FFFF;
		kp = 64'(rate_p);
		// A product this large saturates whatever the derivative term adds.
		if (kp * hi >= (64'd1 << 38)) begin
			res = (s > 0) ? olim : -olim;
		end else begin
			a = longint'((kp * hi << 24) + kp * lo);
			if (s < 0)
				a = -a;
			res = (a + b) / denom;
			if (res > olim)
				res = olim;
			else if (res < -olim)
				res = -olim;
		end
		return res[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			outer_p = RST_OUTER_KP;
			outer_i = RST_OUTER_KI;
			outer_d = RST_OUTER_KD;
			rate_p = RST_INNER_KP;
			rate_d = RST_INNER_KD;
			integ_clamp = RST_INT_LIMIT;
			drive_clamp = RST_OUT_LIMIT;
			angle_err_sum = 0;
			last_angle = 0;
			last_rate = 0;
			drive_q.delete();
			fail_count = 0;
			pending = 0;
			ticks_seen = 0;
			results_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OUTER_KP: outer_p = cfg_data[GAIN_W-1:0];
					REG_OUTER_KI: outer_i = cfg_data[GAIN_W-1:0];
					REG_OUTER_KD: outer_d = cfg_data[GAIN_W-1:0];
					REG_INNER_KP: rate_p = cfg_data[GAIN_W-1:0];
					REG_INNER_KD: rate_d = cfg_data[GAIN_W-1:0];
					REG_INT_LIMIT: integ_clamp = cfg_data[ILIM_W-1:0];
					REG_OUT_LIMIT: drive_clamp = cfg_data[OLIM_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (drive_q.size() == 0) begin
					$error("drive_value: unexpected transaction, value %0d",
						$signed(m_tdata));
					fail_count++;
				end else begin
					want = drive_q.pop_front();
					if (m_tdata !== want) begin
						$error("drive_value mismatch: expected %0d, actual %0d", want,
							$signed(m_tdata));
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				ticks_seen++;
				drive_q.push_back(predict_drive(s_tdata[15:0], s_tdata[31:16],
					s_tdata[47:32]));
			end
			pending = drive_q.size();
		end
	end

endmodule

>>> verif/cascaded_angle_rate_pid_tb.sv
// Testbench top for the cascaded angle and rate controller: stimulus, register phases and verdict.
module cascaded_angle_rate_pid_tb;
	import carp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 8;
	localparam int TICKS_PER_PHASE = 250;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_LONG_STALL, RX_PERIODIC} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata = '0;   // target_angle[15:0], gyro_rate[31:16], measured_angle[47:32]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;        // drive_value[15:0]
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, pending, ticks_seen, results_checked;
	int cycle_count = 0;
	int burst_left = 0;
	int settings_used = 1;
	bit tx_steady = 1'b0;
	logic signed [15:0] held_target = '0;

	rx_mode_t rx_mode = RX_ALWAYS;
	int rx_left = 0;
	int rx_hold = 0;
	int rx_phase = 0;

	cascaded_angle_rate_pid u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cascaded_angle_rate_pid_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.ticks_seen(ticks_seen), .results_checked(results_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(50, 300);
		end else begin
			rx_left--;
		end
		rx_phase = (rx_phase + 1) % 7;
		case (rx_mode)
			RX_ALWAYS: m_tready = 1'b1;
			RX_COIN: m_tready = 1'($urandom_range(0, 1));
			RX_LONG_STALL: begin
				if (rx_hold == 0) begin
					m_tready = !m_tready;
					rx_hold = m_tready ? $urandom_range(1, 5) : $urandom_range(1, 40);
				end else begin
					rx_hold--;
				end
			end
			default: m_tready = (rx_phase < 4);
		endcase
	end

	task automatic send_tick(input logic signed [15:0] tgt, input logic signed [15:0] gyr,
			input logic signed [15:0] mea);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = tx_steady ? 0 : $urandom_range(0, 30);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata = {mea, gyr, tgt};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(input logic [23:0] okp, input logic [23:0] oki,
			input logic [23:0] okd, input logic [23:0] ikp, input logic [23:0] ikd,
			input logic [23:0] ilim, input logic [23:0] olim);
		write_reg(REG_OUTER_KP, okp);
		write_reg(REG_OUTER_KI, oki);
		write_reg(REG_OUTER_KD, okd);
		write_reg(REG_INNER_KP, ikp);
		write_reg(REG_INNER_KD, ikd);
		write_reg(REG_INT_LIMIT, ilim);
		write_reg(REG_OUT_LIMIT, olim);
		settings_used++;
	endtask

	function automatic logic [23:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 24'hFF_FFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 32768));
		endcase
	endfunction

	// Upper bits of limit writes are random so that masking is exercised.
	function automatic logic [23:0] pick_limit(input int width);
		logic [23:0] upper;
		upper = 24'($urandom) & ~((24'd1 << width) - 1);
		case ($urandom_range(0, 5))
			0: return upper;
			1: return upper | ((24'd1 << width) - 1);
			2: return upper | 24'($urandom_range(0, (1 << width) - 1));
			default: return upper | 24'($urandom_range(0, 6000));
		endcase
	endfunction

	task automatic random_ticks(input int count);
		logic signed [15:0] t, g, m;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 3) begin
				t = 16'($urandom);
				g = 16'($urandom);
				m = 16'($urandom);
			end else begin
				if ($urandom_range(0, 15) == 0)
					held_target = 16'($urandom);
				t = held_target;
				m = t + 16'(int'($urandom_range(0, 400)) - 200);
				g = 16'(int'($urandom_range(0, 2000)) - 1000);
			end
			send_tick(t, g, m);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset gains: zero input, angle and rate extremes, integral clamping.
		send_tick(16'sd0, 16'sd0, 16'sd0);
		send_tick(16'sd0, 16'sd0, 16'sd32767);
		send_tick(16'sd0, 16'sd0, -16'sd32768);
		send_tick(16'sd32767, 16'sd0, -16'sd32768);
		send_tick(-16'sd32768, 16'sd0, 16'sd32767);
		send_tick(-16'sd32768, 16'sd0, 16'sd32767);
		send_tick(16'sd0, 16'sd32767, 16'sd0);
		send_tick(16'sd0, -16'sd32768, 16'sd0);
		send_tick(16'sd0, 16'sd32767, 16'sd0);
		send_tick(16'sd5, 16'sd3, 16'sd4);
		settle();

		// Every gain and limit at its maximum: extreme inputs drive the inner product into saturation.
		write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
			24'hFF_FFFF, 24'hFF_FFFF);
		send_tick(-16'sd32768, 16'sd32767, 16'sd32767);
		send_tick(16'sd32767, -16'sd32768, -16'sd32768);
		send_tick(16'sd0, 16'sd0, 16'sd0);
		send_tick(16'sd1, 16'sd0, 16'sd0);
		settle();

		// Zero limits hold the integral and the output at zero; an unused index is ignored.
		write_all(24'd40960, 24'd4096, 24'd8192, 24'd4096, 24'd4096, 24'd0, 24'd0);
		write_reg(REG_UNUSED, 24'hFF_FFFF);
		send_tick(16'sd100, 16'sd50, -16'sd200);
		send_tick(-16'sd300, -16'sd20, 16'sd400);
		send_tick(16'sd7, 16'sd0, 16'sd7);
		settle();
		write_reg(REG_OUT_LIMIT, 24'h00_7FFF);
		send_tick(16'sd100, 16'sd50, -16'sd200);
		send_tick(-16'sd300, -16'sd20, 16'sd400);
		send_tick(16'sd0, -16'sd5, 16'sd1);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				write_all(RST_OUTER_KP, RST_OUTER_KI, RST_OUTER_KD, RST_INNER_KP,
					RST_INNER_KD, 24'(RST_INT_LIMIT), 24'(RST_OUT_LIMIT));
			else
				write_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
					pick_limit(ILIM_W), pick_limit(OLIM_W));
			tx_steady = (p % 3 == 0);
			random_ticks(TICKS_PER_PHASE);
			settle();
		end

		$display("Run covered %0d control ticks and %0d drive results under %0d register settings.",
			ticks_seen, results_checked, settings_used);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
